### hw/rtl/sdac_pkg.sv
// Shared constants, types and the binary-to-BCD step for the decimal text converter.
package sdac_pkg;

  localparam int BinW         = 32;
  localparam int NumDigits    = 10;
  localparam int DigitW       = 4;
  localparam int BcdW         = NumDigits * DigitW;
  localparam int BitsPerStage = 4;
  localparam int NumStages    = BinW / BitsPerStage;
  localparam int PosW         = $clog2(NumDigits);
  localparam int CharW        = 8;

  localparam logic [CharW-1:0] CharMinus = 8'd45;
  localparam logic [CharW-1:0] CharZero  = 8'd48;

  typedef struct packed {
    logic            neg;
    logic [BinW-1:0] bin;
    logic [BcdW-1:0] bcd;
  } sdac_word_t;

  function automatic logic [BcdW-1:0] dabble_bits(input logic [BcdW-1:0] bcd_in,
                                                  input logic [BitsPerStage-1:0] bits);
    logic [BcdW-1:0] b;
    b = bcd_in;
    for (int s = 0; s < BitsPerStage; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[d*DigitW +: DigitW] >= 4'd5) begin
          b[d*DigitW +: DigitW] = b[d*DigitW +: DigitW] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], bits[BitsPerStage-1-s]};
    end
    return b;
  endfunction

endpackage

### hw/rtl/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text converter, top level.
//
// Input channel: in_valid/in_ready with value, a two's complement integer.
// Output channel: out_valid/out_ready with character (ASCII) and last_char,
// high on the final character of each number's text. Each number gives a
// leading '-' when negative, then its digits without leading zeros, so
// between 1 and 11 characters.
// An input register forms the magnitude, eight pipeline stages each convert
// four bits to BCD, and a sequencer sends one character per cycle while the
// receiver is ready through an output register. The first character of a
// number passes the input register, the stages, the sequencer and the output
// register; the rest follow one per cycle while the receiver is ready. The
// sequencer takes a new number in as it sends the final character of the one before.
// Reset clears every valid bit; nothing is output until a new transfer in.
// When the receiver stalls, the output holds and the pipeline fills up and
// then holds its stages; nothing is lost or repeated.
module signed_int_to_decimal_ascii_core
  import sdac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [BinW-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CharW-1:0]       character,
  output logic                   last_char
);

  logic       stage_valid [0:NumStages];
  logic       stage_ready [0:NumStages];
  sdac_word_t stage_word  [0:NumStages];

  logic       valid;
  sdac_word_t word;
  logic [BinW-1:0] mag;

  assign mag = value[BinW-1] ? (BinW'(0) - $unsigned(value)) : $unsigned(value);

  assign in_ready       = !valid || stage_ready[0];
  assign stage_valid[0] = valid;
  assign stage_word[0]  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      word.neg <= value[BinW-1];
      word.bin <= mag;
      word.bcd <= '0;
    end
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    sdac_dabble_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stage_valid[i]),
      .in_ready (stage_ready[i]),
      .in_word  (stage_word[i]),
      .out_valid(stage_valid[i+1]),
      .out_ready(stage_ready[i+1]),
      .out_word (stage_word[i+1])
    );
  end

  sdac_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[NumStages]),
    .in_ready (stage_ready[NumStages]),
    .in_word  (stage_word[NumStages]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last_char(last_char)
  );

endmodule

### hw/rtl/sdac_dabble_stage.sv
// One pipeline stage of the shift-and-add-3 binary to BCD conversion.
module sdac_dabble_stage
  import sdac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sdac_word_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output sdac_word_t out_word
);

  logic       valid;
  sdac_word_t word;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      word.neg <= in_word.neg;
      word.bin <= in_word.bin << BitsPerStage;
      word.bcd <= dabble_bits(in_word.bcd, in_word.bin[BinW-1 -: BitsPerStage]);
    end
  end

endmodule

### hw/rtl/sdac_serializer.sv
// Character sequencer: sign, then significant digits, through an output register.
module sdac_serializer
  import sdac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdac_word_t       in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] character,
  output logic             last_char
);

  logic             busy;
  logic             neg_pend;
  logic [BcdW-1:0]  bcd;
  logic [PosW-1:0]  pos;
  logic             ovalid;
  logic [CharW-1:0] ochar;
  logic             olast;

  logic             advance;
  logic             emit;
  logic             finish;
  logic             load;
  logic [PosW-1:0]  top_idx;
  logic [DigitW-1:0] cur;

  always_comb begin
    top_idx = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (in_word.bcd[d*DigitW +: DigitW] != '0) begin
        top_idx = PosW'(d);
      end
    end
  end

  assign cur      = bcd[DigitW*pos +: DigitW];
  assign advance  = !ovalid || out_ready;
  assign emit     = busy && advance;
  assign finish   = emit && !neg_pend && (pos == '0);
  assign in_ready = !busy || finish;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (advance) begin
        ovalid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg_pend <= in_word.neg;
      pos      <= top_idx;
      bcd      <= in_word.bcd;
    end else if (emit) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        pos <= pos - 1'b1;
      end
    end
    if (emit) begin
      if (neg_pend) begin
        ochar <= CharMinus;
        olast <= 1'b0;
      end else begin
        ochar <= CharZero + {{(CharW-DigitW){1'b0}}, cur};
        olast <= (pos == '0);
      end
    end
  end

  assign out_valid = ovalid;
  assign character = ochar;
  assign last_char = olast;

endmodule

### hw/rtl/sdac_checker.sv
// Port-level checks for the decimal text converter, bound to the top level.
module sdac_checker
  import sdac_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic signed [BinW-1:0] value,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [CharW-1:0]       character,
  input logic                   last_char
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last_char))
    else $error("stalled output changed");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CharMinus) ||
                  (character >= CharZero && character <= CharZero + 8'd9))
    else $error("character outside sign and digit codes");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && character == CharMinus |-> !last_char)
    else $error("sign marked as final character");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && character == CharMinus
      |=> !(out_valid && character == CharZero))
    else $error("zero digit after sign");

endmodule

bind signed_int_to_decimal_ascii_core sdac_checker u_checker (.*);

### tb/tb.sv
// Self-checking bench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb;
  import sdac_pkg::*;

  localparam int NumDirected = 20;
  localparam int NumRandom   = 410;
  localparam int StallLimit  = 2000;
  localparam int TailCycles  = 20;
  localparam int Ratio       = 30;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic signed [BinW-1:0] value     = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CharW-1:0]       character;
  logic                   last_char;

  bit                     gaps_on    = 1'b1;
  int                     mismatches = 0;
  int                     quiet_cycles = 0;
  text_char_t             pending_text[$];

  logic [BinW-1:0] dir_value [NumDirected] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
    32'd999999999, 32'hC465_3601,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
    32'd12345, 32'hFFFF_2BCF, 32'h0000_FFFF, 32'hFFFF_0000
  };
  string dir_text [NumDirected] = '{
    "0", "1", "-1", "9", "10", "-10",
    "2147483647", "-2147483648", "-2147483647", "1000000000",
    "999999999", "-999999999",
    "", "", "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .last_char(last_char)
  );

  always #10 clk = ~clk;

  function automatic void push_decimal_text(input logic [BinW-1:0] bits);
    logic            neg;
    logic [BinW-1:0] mag;
    logic [3:0]      digs [NumDigits];
    int              n;
    neg = bits[BinW-1];
    mag = neg ? (~bits + 1'b1) : bits;
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0 && n < NumDigits);
    if (neg) pending_text.push_back('{CharMinus, 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      pending_text.push_back('{CharZero + CharW'(digs[k]), k == 0});
    end
  endfunction

  function automatic void push_typed_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_text.push_back('{CharW'(s[i]), i == s.len() - 1});
    end
  endfunction

  function automatic logic [BinW-1:0] random_value();
    logic [BinW-1:0] v;
    logic [BinW-1:0] p;
    int              pick;
    pick = $urandom_range(9);
    unique case (pick)
      4: begin
        v = BinW'($urandom_range(40)) - BinW'(20);
      end
      5: begin
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        v = p + BinW'($urandom_range(2)) - BinW'(1);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      6: begin
        if ($urandom_range(1)) v = 32'h8000_0000 + BinW'($urandom_range(3));
        else v = 32'h7FFF_FFFF - BinW'($urandom_range(3));
      end
      7: begin
        v = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [BinW-1:0] v, input string text, input bit drain);
    int gap;
    gap = 0;
    if (gaps_on) while ($urandom_range(99) < Ratio) gap++;
    if (drain || gap > 0) begin
      in_valid <= 1'b0;
      if (drain) begin
        do @(posedge clk); while (pending_text.size() != 0);
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (text != "") push_typed_text(text);
    else push_decimal_text(v);
  endtask

  always @(posedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(99) >= Ratio);
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected transfer out: character %0d last_char %0d",
                   character, last_char);
        end
      end else begin
        want = pending_text.pop_front();
        if (character !== want.ch || last_char !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("character: expected %0d last_char %0d, got %0d last_char %0d",
                     want.ch, want.last, character, last_char);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("signed_int_to_decimal_ascii_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NumDirected; i++) begin
      send_value(dir_value[i], dir_text[i], 1'b0);
    end
    for (int i = 0; i < NumRandom; i++) begin
      gaps_on = !(i >= 150 && i < 280);
      send_value(random_value(), "", i == 0 || i == 300);
    end
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii_core: match");
    end else begin
      $display("signed_int_to_decimal_ascii_core: mismatch");
    end
    $finish;
  end

endmodule
